// File: design/u8u16dec_pkg.sv
`default_nettype none

package u8u16dec_pkg;

    typedef enum logic [1:0] {
        MODE_UTF8    = 2'd0,
        MODE_UTF16LE = 2'd1,
        MODE_UTF16BE = 2'd2,
        MODE_NONE    = 2'd3
    } mode_t;

    localparam logic [20:0] REPLACEMENT_CP     = 21'h00FFFD;
    localparam logic [20:0] CP_CR              = 21'h00000D;
    localparam logic [20:0] CP_LF              = 21'h00000A;
    localparam logic [20:0] SUPPLEMENTARY_BASE = 21'h010000;
    localparam logic [15:0] UNIT_CR            = 16'h000D;
    localparam logic [15:0] UNIT_LF            = 16'h000A;
    localparam logic [5:0]  LEAD_PREFIX        = 6'b110110;
    localparam logic [5:0]  TRAIL_PREFIX       = 6'b110111;

    localparam int OUT_DEPTH = 4;
    localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
    localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_stream;
    } in_item_t;

    typedef struct packed {
        logic [20:0] code_point;
        logic        is_error;
        logic        last_of_run;
    } out_item_t;

    typedef struct packed {
        logic [20:0] code_point;
        logic        is_error;
    } code_result_t;

    typedef struct packed {
        logic [1:0]              count;
        code_result_t [1:0]      res;
    } dec_out_t;

    typedef struct packed {
        logic [1:0]  bytes_remaining;
        logic [20:0] accumulator;
        logic        half_valid;
        logic [7:0]  half_byte;
        logic        lead_valid;
        logic [9:0]  lead_bits;
        logic        cr_pending;
    } dec_state_t;

endpackage

`default_nettype wire

// File: design/u8u16dec_core.sv
`default_nettype none

module u8u16dec_core
    import u8u16dec_pkg::*;
(
    input  wire mode_t      mode,
    input  wire dec_state_t state_cur,
    input  wire in_item_t   item,
    output dec_state_t      state_next,
    output dec_out_t        result
);

    function automatic dec_out_t push(dec_out_t r, logic [20:0] cp, logic err);
        dec_out_t o;
        o = r;
        if (r.count == 2'd0)
        begin
            o.res[0].code_point = cp;
            o.res[0].is_error   = err;
            o.count             = 2'd1;
        end
        else
        begin
            o.res[1].code_point = cp;
            o.res[1].is_error   = err;
            o.count             = 2'd2;
        end
        return o;
    endfunction

    dec_state_t  st;
    dec_out_t    ro;
    logic [15:0] unit;
    logic [20:0] pair_cp;
    logic [20:0] acc_shift;
    logic        do_fresh;
    logic        is_lead;
    logic [7:0]  b;
    logic        eos;

    always_comb
    begin
        st        = state_cur;
        ro        = '0;
        b         = item.in_byte;
        eos       = item.end_of_stream;
        unit      = (mode == MODE_UTF16BE) ? {state_cur.half_byte, b}
                                           : {b, state_cur.half_byte};
        pair_cp   = SUPPLEMENTARY_BASE + {1'b0, state_cur.lead_bits, unit[9:0]};
        acc_shift = {state_cur.accumulator[14:0], b[5:0]};
        do_fresh  = 1'b0;
        is_lead   = 1'b0;
        case (mode)
            MODE_UTF8:
            begin
                if (state_cur.bytes_remaining == 2'd0)
                begin
                    if (b[7] == 1'b0)
                    begin
                        ro = push(ro, {13'd0, b}, 1'b0);
                    end
                    else
                    begin
                        is_lead = 1'b1;
                        if (b[7:5] == 3'b110)
                        begin
                            st.accumulator     = {16'd0, b[4:0]};
                            st.bytes_remaining = 2'd1;
                        end
                        else if (b[7:4] == 4'b1110)
                        begin
                            st.accumulator     = {17'd0, b[3:0]};
                            st.bytes_remaining = 2'd2;
                        end
                        else if (b[7:3] == 5'b11110)
                        begin
                            st.accumulator     = {18'd0, b[2:0]};
                            st.bytes_remaining = 2'd3;
                        end
                        else
                        begin
                            is_lead = 1'b0;
                            ro      = push(ro, REPLACEMENT_CP, 1'b1);
                        end
                        if (is_lead && eos)
                        begin
                            st.accumulator     = '0;
                            st.bytes_remaining = 2'd0;
                            ro                 = push(ro, REPLACEMENT_CP, 1'b1);
                        end
                    end
                end
                else if (b[7:6] != 2'b10)
                begin
                    st.accumulator     = '0;
                    st.bytes_remaining = 2'd0;
                    ro                 = push(ro, REPLACEMENT_CP, 1'b1);
                end
                else
                begin
                    st.bytes_remaining = state_cur.bytes_remaining - 2'd1;
                    if (state_cur.bytes_remaining == 2'd1)
                    begin
                        st.accumulator = '0;
                        ro             = push(ro, acc_shift, 1'b0);
                    end
                    else if (eos)
                    begin
                        st.accumulator     = '0;
                        st.bytes_remaining = 2'd0;
                        ro                 = push(ro, REPLACEMENT_CP, 1'b1);
                    end
                    else
                    begin
                        st.accumulator = acc_shift;
                    end
                end
            end
            MODE_UTF16LE, MODE_UTF16BE:
            begin
                if (!state_cur.half_valid)
                begin
                    if (!eos)
                    begin
                        st.half_valid = 1'b1;
                        st.half_byte  = b;
                    end
                    else
                    begin
                        if (state_cur.lead_valid)
                        begin
                            ro = push(ro, REPLACEMENT_CP, 1'b1);
                        end
                        else if (state_cur.cr_pending)
                        begin
                            ro = push(ro, CP_CR, 1'b0);
                        end
                        st.lead_valid = 1'b0;
                        st.lead_bits  = '0;
                        st.cr_pending = 1'b0;
                        ro            = push(ro, REPLACEMENT_CP, 1'b1);
                    end
                end
                else
                begin
                    st.half_valid = 1'b0;
                    st.half_byte  = '0;
                    do_fresh      = 1'b1;
                    if (state_cur.lead_valid)
                    begin
                        st.lead_valid = 1'b0;
                        st.lead_bits  = '0;
                        if (unit[15:10] == TRAIL_PREFIX)
                        begin
                            ro       = push(ro, pair_cp, 1'b0);
                            do_fresh = 1'b0;
                        end
                        else
                        begin
                            ro = push(ro, REPLACEMENT_CP, 1'b1);
                        end
                    end
                    else if (state_cur.cr_pending)
                    begin
                        st.cr_pending = 1'b0;
                        if (unit == UNIT_LF)
                        begin
                            ro       = push(ro, CP_LF, 1'b0);
                            do_fresh = 1'b0;
                        end
                        else
                        begin
                            ro = push(ro, CP_CR, 1'b0);
                        end
                    end
                    if (do_fresh)
                    begin
                        if (unit[15:10] == LEAD_PREFIX)
                        begin
                            if (eos)
                            begin
                                ro = push(ro, REPLACEMENT_CP, 1'b1);
                            end
                            else
                            begin
                                st.lead_valid = 1'b1;
                                st.lead_bits  = unit[9:0];
                            end
                        end
                        else if (unit[15:10] == TRAIL_PREFIX)
                        begin
                            ro = push(ro, REPLACEMENT_CP, 1'b1);
                        end
                        else if (unit == UNIT_CR)
                        begin
                            if (eos)
                            begin
                                ro = push(ro, CP_CR, 1'b0);
                            end
                            else
                            begin
                                st.cr_pending = 1'b1;
                            end
                        end
                        else
                        begin
                            ro = push(ro, {5'd0, unit}, 1'b0);
                        end
                    end
                end
            end
            default:
            begin
                ro = push(ro, REPLACEMENT_CP, 1'b1);
            end
        endcase
        state_next = st;
        result     = ro;
    end

endmodule

`default_nettype wire

// File: design/utf8_utf16_code_point_decoder.sv
// Each result is written into the result queue on the input transfer that causes it.
// Throughput: one byte per cycle while in_stall is low and each byte yields at most
// one result; the two results of a byte are queued together but leave one at a time.
// Input is stalled while the four-entry result queue cannot take two more results.
// Reset (rst_n, asynchronous, active low) selects UTF-8 and clears all decode state.
`default_nettype none

module utf8_utf16_code_point_decoder
    import u8u16dec_pkg::*;
(
    input  wire            clk,
    input  wire            rst_n,
    input  wire            cfg_write_enable,
    input  wire [1:0]      cfg_write_data,
    input  wire            in_valid,
    output logic           in_stall,
    input  wire in_item_t  in_item,
    output logic           out_valid,
    input  wire            out_stall,
    output out_item_t      out_item
);

    mode_t                mode_reg;
    dec_state_t           state_reg;
    dec_state_t           state_next;
    dec_out_t             dec_result;
    out_item_t            queue_reg [OUT_DEPTH];
    logic [OUT_PTR_W-1:0] wr_ptr_reg;
    logic [OUT_PTR_W-1:0] rd_ptr_reg;
    logic [OUT_CNT_W-1:0] count_reg;
    logic [OUT_CNT_W-1:0] count_next;
    logic                 in_accept;
    logic                 out_accept;
    logic [OUT_CNT_W-1:0] push_count;
    out_item_t            first_item;
    out_item_t            second_item;

    u8u16dec_core u_core (
        .mode       (mode_reg),
        .state_cur  (state_reg),
        .item       (in_item),
        .state_next (state_next),
        .result     (dec_result)
    );

    assign in_stall   = (count_reg > OUT_CNT_W'(OUT_DEPTH - 2));
    assign in_accept  = in_valid && !in_stall;
    assign out_valid  = (count_reg != '0);
    assign out_accept = out_valid && !out_stall;
    assign out_item   = queue_reg[rd_ptr_reg];

    always_comb
    begin
        push_count = in_accept ? OUT_CNT_W'(dec_result.count) : '0;
        count_next = count_reg + push_count - OUT_CNT_W'(out_accept);
        first_item.code_point  = dec_result.res[0].code_point;
        first_item.is_error    = dec_result.res[0].is_error;
        first_item.last_of_run = (dec_result.count == 2'd1);
        second_item.code_point  = dec_result.res[1].code_point;
        second_item.is_error    = dec_result.res[1].is_error;
        second_item.last_of_run = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_UTF8;
            state_reg  <= '0;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (cfg_write_enable)
            begin
                mode_reg  <= mode_t'(cfg_write_data);
                state_reg <= '0;
            end
            else if (in_accept)
            begin
                state_reg <= state_next;
            end
            wr_ptr_reg <= wr_ptr_reg + OUT_PTR_W'(push_count);
            if (out_accept)
            begin
                rd_ptr_reg <= rd_ptr_reg + OUT_PTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept && (dec_result.count != 2'd0))
        begin
            queue_reg[wr_ptr_reg] <= first_item;
        end
        if (in_accept && (dec_result.count == 2'd2))
        begin
            queue_reg[wr_ptr_reg + OUT_PTR_W'(1)] <= second_item;
        end
    end

endmodule

`default_nettype wire
